// ----- src/uaq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uaq_pkg
// Shared widths, register indexes and reset values of the ultrasonic
// altitude qualifier.
// ---------------------------------------------------------------------------
package uaq_pkg;

  // field widths
  localparam int HEIGHT_W = 10;
  localparam int SPEED_W  = 13;
  localparam int LIMIT_W  = 12;
  localparam int TICK_W   = 8;
  localparam int DECAY_W  = 4;
  localparam int RAW_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int RATE_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MAX_RANGE  = 3'd0;
  localparam cfg_idx_t REG_MAX_JUMP   = 3'd1;
  localparam cfg_idx_t REG_SPEED_LIM  = 3'd2;
  localparam cfg_idx_t REG_FAIL_TICKS = 3'd3;
  localparam cfg_idx_t REG_RATE_PER   = 3'd4;
  localparam cfg_idx_t REG_DECAY_DIV  = 3'd5;

  // register reset values
  localparam logic [HEIGHT_W-1:0] RST_MAX_RANGE  = 10'd220;
  localparam logic [HEIGHT_W-1:0] RST_MAX_JUMP   = 10'd50;
  localparam logic [LIMIT_W-1:0]  RST_SPEED_LIM  = 12'd500;
  localparam logic [TICK_W-1:0]   RST_FAIL_TICKS = 8'd8;
  localparam logic [TICK_W-1:0]   RST_RATE_PER   = 8'd10;
  localparam logic [DECAY_W-1:0]  RST_DECAY_DIV  = 4'd5;

  // filter state reset
  localparam logic [HEIGHT_W-1:0] RST_GOOD_HEIGHT = 10'd20;

  // cm per ms to mm per s
  localparam int SPEED_SCALE = 10000;

  // dividend of the serial divider: 1023 * 10000 fits in 24 bits
  localparam int DIVN_W = 24;
  localparam int DCNT_W = $clog2(DIVN_W);

  localparam logic [TICK_W-1:0] MISSED_MAX = 8'd255;

endpackage

// ----- src/ultrasonic_altitude_qualifier.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ultrasonic_altitude_qualifier
// Qualifies ultrasonic range readings into a height and a vertical speed,
// and tracks sensor health with a missed-reading counter and a rate sample.
// ---------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | func, reading_present, range_raw, time_ms
//  out     | out_valid/out_stall | height_cm, speed_mm_s, height_updated,
//          |                     | sensor_fail, reading_rate
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request in flight at a time; a new one is taken once the last has
// reached the output register, which may still be waiting to be taken.
// Monitor tick: IDLE, EMIT. Measurement with a zero height: IDLE, PREP, EMIT.
// Measurement through the filter: IDLE, PREP, LOAD, DIV, FIN, EMIT, with DIV the
// radix-2 restoring divider that shifts one dividend bit per cycle;
// an accepted reading with a zero interval skips DIV. Synchronous active-low
// reset restores state, configuration, filter and monitor registers and clears
// out_valid. A stalled output holds its request and keeps in_stall high.
// ---------------------------------------------------------------------------
module ultrasonic_altitude_qualifier #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // measurement / tick requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic                            in_reading_present,
  input  logic [uaq_pkg::RAW_W-1:0]       in_range_raw,
  input  logic [uaq_pkg::STAMP_W-1:0]     in_time_ms,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [uaq_pkg::HEIGHT_W-1:0]    out_height_cm,
  output logic signed [uaq_pkg::SPEED_W-1:0] out_speed_mm_s,
  output logic                            out_height_updated,
  output logic                            out_sensor_fail,
  output logic [uaq_pkg::RATE_W-1:0]      out_reading_rate,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uaq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uaq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import uaq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [HEIGHT_W-1:0] max_range_r, max_jump_r;
  logic [LIMIT_W-1:0]  speed_lim_r;
  logic [TICK_W-1:0]   fail_ticks_r, rate_per_r;
  logic [DECAY_W-1:0]  decay_div_r;

  // filter and monitor state
  logic [HEIGHT_W-1:0]       last_raw_r, good_height_r, shown_height_r;
  logic [TIME_BITS-1:0]      good_time_r;
  logic signed [SPEED_W-1:0] speed_est_r;
  logic [TICK_W-1:0]         missed_r, phase_r;
  logic                      fail_r;
  logic [COUNT_BITS-1:0]     count_r, snapshot_r;
  logic [RATE_W-1:0]         rate_r;

  // per-request working registers
  logic [TIME_BITS-1:0] now_r, dt_r;
  logic                 updated_r, reject_r, diff_neg_r, sneg_r;
  logic [HEIGHT_W-1:0]  mag_r;

  // serial divider: dividend shifts out as quotient shifts in
  logic [DIVN_W-1:0]    div_n_r;
  logic [TIME_BITS-1:0] div_d_r, div_rem_r;
  logic [DCNT_W-1:0]    div_cnt_r;

  // output register
  logic                      out_valid_r, out_updated_r, out_fail_r;
  logic [HEIGHT_W-1:0]       out_height_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic [RATE_W-1:0]         out_rate_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  // time stamp fitted to TIME_BITS
  logic [TIME_BITS+STAMP_W-1:0] stamp_wide;
  logic [TIME_BITS-1:0]         now_nxt;
  assign stamp_wide = {{TIME_BITS{1'b0}}, in_time_ms};
  assign now_nxt    = stamp_wide[TIME_BITS-1:0];

  // clamp of the raw range
  logic [HEIGHT_W-1:0] raw_clamp_nxt;
  assign raw_clamp_nxt = (in_range_raw > RAW_W'(max_range_r)) ? max_range_r
                                                              : in_range_raw[HEIGHT_W-1:0];

  // tick bookkeeping
  logic [TICK_W-1:0]     missed_nxt, phase_nxt;
  logic [COUNT_BITS-1:0] rate_diff;
  logic [COUNT_BITS+RATE_W-1:0] rate_wide;
  logic [RATE_W-1:0]     rate_nxt;
  assign missed_nxt = (missed_r == MISSED_MAX) ? MISSED_MAX : missed_r + 1'b1;
  assign phase_nxt  = phase_r + 1'b1;
  assign rate_diff  = count_r - snapshot_r;
  assign rate_wide  = {{RATE_W{1'b0}}, rate_diff};
  assign rate_nxt   = rate_wide[RATE_W-1:0];

  // height change against the last good height
  logic signed [HEIGHT_W:0] diff_nxt;
  logic [HEIGHT_W:0]        diff_abs;
  logic [HEIGHT_W-1:0]      mag_nxt;
  assign diff_nxt = signed'({1'b0, last_raw_r}) - signed'({1'b0, good_height_r});
  assign diff_abs = diff_nxt[HEIGHT_W] ? (HEIGHT_W+1)'(0) - diff_nxt : diff_nxt;
  assign mag_nxt  = diff_abs[HEIGHT_W-1:0];

  // magnitude of the current speed
  logic [SPEED_W-1:0] speed_abs;
  assign speed_abs = speed_est_r[SPEED_W-1] ? SPEED_W'(0) - speed_est_r : speed_est_r;

  // one restoring divide step
  logic [TIME_BITS:0]   rem_sh;
  logic                 rem_ge;
  logic [TIME_BITS:0]   rem_sub;
  assign rem_sh  = {div_rem_r, div_n_r[DIVN_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_d_r};
  assign rem_sub = rem_sh - {1'b0, div_d_r};

  // quotient to signed speed
  logic [LIMIT_W-1:0]  q_mag;
  logic                q_neg;
  logic [SPEED_W-1:0]  q_speed;
  assign q_mag   = (!reject_r && (div_n_r > DIVN_W'(speed_lim_r))) ? speed_lim_r
                                                                  : div_n_r[LIMIT_W-1:0];
  assign q_neg   = reject_r ? sneg_r : diff_neg_r;
  assign q_speed = q_neg ? SPEED_W'(0) - {1'b0, q_mag} : {1'b0, q_mag};

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      max_range_r    <= RST_MAX_RANGE;
      max_jump_r     <= RST_MAX_JUMP;
      speed_lim_r    <= RST_SPEED_LIM;
      fail_ticks_r   <= RST_FAIL_TICKS;
      rate_per_r     <= RST_RATE_PER;
      decay_div_r    <= RST_DECAY_DIV;
      last_raw_r     <= '0;
      good_height_r  <= RST_GOOD_HEIGHT;
      good_time_r    <= '0;
      speed_est_r    <= '0;
      shown_height_r <= '0;
      missed_r       <= '0;
      fail_r         <= 1'b0;
      count_r        <= '0;
      snapshot_r     <= '0;
      phase_r        <= '0;
      rate_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_RANGE:  max_range_r  <= cfg_data[HEIGHT_W-1:0];
          REG_MAX_JUMP:   max_jump_r   <= cfg_data[HEIGHT_W-1:0];
          REG_SPEED_LIM:  speed_lim_r  <= cfg_data[LIMIT_W-1:0];
          REG_FAIL_TICKS: fail_ticks_r <= cfg_data[TICK_W-1:0];
          REG_RATE_PER:   rate_per_r   <= cfg_data[TICK_W-1:0];
          REG_DECAY_DIV:  decay_div_r  <= cfg_data[DECAY_W-1:0];
          default: ;
        endcase
      end

      // output register drains when taken, unless refilled in ST_EMIT
      if (out_acc && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            now_r     <= now_nxt;
            updated_r <= 1'b0;
            if (!in_func) begin
              // measurement slot
              if (in_reading_present) begin
                last_raw_r <= raw_clamp_nxt;
                missed_r   <= '0;
                fail_r     <= 1'b0;
                count_r    <= count_r + 1'b1;
              end
              state_r <= ST_PREP;
            end else begin
              // monitor tick
              missed_r <= missed_nxt;
              if (missed_nxt >= fail_ticks_r) begin
                fail_r <= 1'b1;
              end
              if (phase_nxt >= rate_per_r) begin
                phase_r    <= '0;
                rate_r     <= rate_nxt;
                snapshot_r <= count_r;
              end else begin
                phase_r <= phase_nxt;
              end
              state_r <= ST_EMIT;
            end
          end
        end

        ST_PREP: begin
          // classify the reading
          dt_r       <= now_r - good_time_r;
          mag_r      <= mag_nxt;
          diff_neg_r <= diff_nxt[HEIGHT_W];
          reject_r   <= (last_raw_r >= max_range_r) || (mag_nxt > max_jump_r);
          sneg_r     <= speed_est_r[SPEED_W-1];
          if (last_raw_r != '0) begin
            updated_r <= 1'b1;
            state_r   <= ST_LOAD;
          end else begin
            state_r <= ST_EMIT;
          end
        end

        ST_LOAD: begin
          div_rem_r <= '0;
          div_cnt_r <= '0;
          if (reject_r) begin
            // decay: |speed| / divisor, zero divisor acts as one
            div_n_r <= DIVN_W'(speed_abs[LIMIT_W-1:0]);
            div_d_r <= (decay_div_r == '0) ? TIME_BITS'(1) : TIME_BITS'(decay_div_r);
            state_r <= ST_DIV;
          end else if (dt_r == '0) begin
            // zero interval saturates by sign
            div_n_r <= (mag_r != '0) ? DIVN_W'(speed_lim_r) : '0;
            state_r <= ST_FIN;
          end else begin
            div_n_r <= DIVN_W'(mag_r) * DIVN_W'(SPEED_SCALE);
            div_d_r <= dt_r;
            state_r <= ST_DIV;
          end
        end

        ST_DIV: begin
          div_rem_r <= rem_ge ? rem_sub[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
          div_n_r   <= {div_n_r[DIVN_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DCNT_W'(DIVN_W - 1)) begin
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          speed_est_r <= q_speed;
          if (reject_r) begin
            shown_height_r <= good_height_r;
          end else begin
            shown_height_r <= last_raw_r;
            good_height_r  <= last_raw_r;
            good_time_r    <= now_r;
          end
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_height_r  <= shown_height_r;
            out_speed_r   <= speed_est_r;
            out_updated_r <= updated_r;
            out_fail_r    <= fail_r;
            out_rate_r    <= rate_r;
            state_r       <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_height_cm      = out_height_r;
  assign out_speed_mm_s     = out_speed_r;
  assign out_height_updated = out_updated_r;
  assign out_sensor_fail    = out_fail_r;
  assign out_reading_rate   = out_rate_r;

endmodule

// ----- src/uaq_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uaq_checker
// Port-level checks on the altitude qualifier, bound to the top level.
// ---------------------------------------------------------------------------
module uaq_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [uaq_pkg::HEIGHT_W-1:0]       out_height_cm,
  input logic signed [uaq_pkg::SPEED_W-1:0] out_speed_mm_s,
  input logic                               out_height_updated
);
  import uaq_pkg::*;

  // one request at a time: the block is busy right after taking one
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in work");

  // a held result stays put
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_height_cm)
                                  && $stable(out_speed_mm_s)))
    else $error("stalled result changed");

  // a filtered request always shows a non-zero height
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_height_updated) |-> (out_height_cm != '0))
    else $error("updated result with zero height");

  // speed magnitude never exceeds the 12-bit clamp
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_speed_mm_s != {1'b1, {(SPEED_W-1){1'b0}}}))
    else $error("speed outside signed 12-bit magnitude");

endmodule

bind ultrasonic_altitude_qualifier uaq_checker u_uaq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_height_cm      (out_height_cm),
  .out_speed_mm_s     (out_speed_mm_s),
  .out_height_updated (out_height_updated)
);
